@@ sv/krel_pkg.sv @@
// ----------------------------------------------------------------------------
// krel_pkg
// Shared constants and types for the K-out-of-N reliability block.
// ----------------------------------------------------------------------------
package krel_pkg;

    // Probability words are unsigned Q1.31, so 1.0 is 2^31.
    localparam int unsigned PROB_W = 32;
    localparam int unsigned FRAC_W = 31;
    localparam logic [PROB_W-1:0] Q_ONE  = 32'h8000_0000;
    localparam logic [PROB_W-1:0] Q_HALF = 32'h4000_0000;

    // Width of the min_working configuration register.
    localparam int unsigned CFG_W = 6;

    // Control broadcast from the top level to every cell in the row.
    typedef struct packed {
        logic update;   // an item is accepted this cycle
        logic zeroed;   // the stored levels read as zero (new system)
    } krel_ctrl_t;

endpackage

@@ sv/krel_cell.sv @@
// ----------------------------------------------------------------------------
// krel_cell
// One cell of the row: holds P_j and mixes it toward its lower neighbor.
// ----------------------------------------------------------------------------
module krel_cell
    import krel_pkg::*;
(
    input  logic              clk,
    input  krel_ctrl_t        ctrl,
    input  logic [PROB_W-1:0] p,
    input  logic [PROB_W-1:0] below,
    output logic [PROB_W-1:0] level,
    output logic [PROB_W-1:0] held
);

    localparam int unsigned DIFF_W = PROB_W + 1;
    localparam int unsigned ACC_W  = 2 * DIFF_W;

    logic [PROB_W-1:0]       held_reg;
    logic [PROB_W-1:0]       held_next;
    logic [PROB_W-1:0]       here;
    logic signed [DIFF_W-1:0] diff;
    logic signed [ACC_W-1:0]  acc;
    logic [PROB_W-1:0]       mix;

    // The stored level counts as zero once a system has been closed.
    assign here  = ctrl.zeroed ? '0 : held_reg;
    assign level = here;
    assign held  = held_reg;

    // new = (here * 2^31 + p * (below - here) + 2^30) >> 31, one multiply.
    always_comb
    begin
        diff = $signed({1'b0, below}) - $signed({1'b0, here});
        acc  = $signed({{(ACC_W - PROB_W - FRAC_W){1'b0}}, here, {FRAC_W{1'b0}}})
             + diff * $signed({1'b0, p})
             + $signed(ACC_W'(Q_HALF));
        mix  = acc[FRAC_W +: PROB_W];
        held_next = ctrl.update ? mix : held_reg;
    end

    // Level register.
    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule

@@ sv/krel_out.sv @@
// ----------------------------------------------------------------------------
// krel_out
// Result stage: picks P_K from the closed row and holds it for the receiver.
// ----------------------------------------------------------------------------
module krel_out
    import krel_pkg::*;
#(
    parameter int MAX_K = 32,
    parameter int IW    = 5
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         take,
    input  logic                         take_one,
    input  logic [IW-1:0]                take_idx,
    input  logic [MAX_K-1:0][PROB_W-1:0] held,
    input  logic                         result_stall,
    output logic                         result_valid,
    output logic [PROB_W-1:0]            system_reliability,
    output logic                         hold_input
);

    logic              pend_reg;
    logic              pend_next;
    logic              one_reg;
    logic              one_next;
    logic [IW-1:0]     idx_reg;
    logic [IW-1:0]     idx_next;
    logic              valid_reg;
    logic              valid_next;
    logic [PROB_W-1:0] data_reg;
    logic [PROB_W-1:0] data_next;
    logic              move;
    logic [PROB_W-1:0] picked;

    // A closed system moves out when the output register is free or draining.
    assign move       = pend_reg && (!valid_reg || !result_stall);
    assign hold_input = pend_reg && !move;

    // Tap selection, with K of zero giving P_0 and a cap at one.
    always_comb
    begin
        if (one_reg)
        begin
            picked = Q_ONE;
        end
        else if (held[idx_reg] > Q_ONE)
        begin
            picked = Q_ONE;
        end
        else
        begin
            picked = held[idx_reg];
        end
    end

    // Next state for the pending flag and the output register.
    always_comb
    begin
        pend_next  = pend_reg;
        one_next   = one_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (take)
        begin
            pend_next = 1'b1;
            one_next  = take_one;
            idx_next  = take_idx;
        end
        else if (move)
        begin
            pend_next = 1'b0;
        end
        if (move)
        begin
            valid_next = 1'b1;
            data_next  = picked;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        one_reg  <= one_next;
        idx_reg  <= idx_next;
        data_reg <= data_next;
    end

    assign result_valid       = valid_reg;
    assign system_reliability = data_reg;

endmodule

@@ sv/k_out_of_n_reliability.sv @@
// ----------------------------------------------------------------------------
// k_out_of_n_reliability
// Streaming K-out-of-N system reliability over a row of mixing cells.
// ----------------------------------------------------------------------------
// The block takes one component item per clock cycle unless stalled. A row
// of MAX_K cells holds P_1..P_MAX_K, and every cell updates on each item with
// one multiplier of its own, so items stream back to back. The item marked
// last closes the system: it is registered as pending, and once the output
// register is free P_K (capped to 1.0, or 1.0 when K is zero) moves into
// it, and the row already reads as zero for the next system. The input stalls
// only while a closed system still waits in the row because the output
// register is held by the receiver. K is taken from min_working at the last
// item and is clamped to MAX_K. The configuration port is always ready.
// ----------------------------------------------------------------------------
module k_out_of_n_reliability
    import krel_pkg::*;
#(
    parameter int MAX_K = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  min_working,
    input  logic              component_valid,
    output logic              component_stall,
    input  logic [PROB_W-1:0] component_reliability,
    input  logic              last_component,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [PROB_W-1:0] system_reliability
);

    localparam int IW     = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int KCW_LO = $clog2(MAX_K + 1);
    localparam int KCW    = (KCW_LO > CFG_W) ? KCW_LO : CFG_W;

    logic [CFG_W-1:0]             k_reg;
    logic [CFG_W-1:0]             k_next;
    logic                         zero_reg;
    logic                         zero_next;
    logic                         accept;
    logic                         hold_input;
    logic [PROB_W-1:0]            p_sat;
    logic [KCW-1:0]               k_wide;
    logic [KCW-1:0]               k_lim;
    logic                         k_one;
    logic [IW-1:0]                k_idx;
    krel_ctrl_t                   ctrl;
    logic [MAX_K-1:0][PROB_W-1:0] level;
    logic [MAX_K-1:0][PROB_W-1:0] held;

    // Handshakes.
    assign cfg_ready       = 1'b1;
    assign component_stall = hold_input;
    assign accept          = component_valid && !component_stall;

    // A reliability above one saturates to one.
    assign p_sat = (component_reliability > Q_ONE) ? Q_ONE : component_reliability;

    // K clamped to the row length; K of zero selects P_0.
    always_comb
    begin
        k_wide = KCW'(k_reg);
        k_lim  = (k_wide > KCW'(MAX_K)) ? KCW'(MAX_K) : k_wide;
        k_one  = (k_lim == '0);
        k_idx  = IW'(k_lim - KCW'(1));
    end

    // Configuration write and the row-cleared flag.
    always_comb
    begin
        k_next    = (cfg_valid && cfg_ready) ? min_working : k_reg;
        zero_next = accept ? last_component : zero_reg;
        ctrl.update = accept;
        ctrl.zeroed = zero_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= CFG_W'(1);
            zero_reg <= 1'b1;
        end
        else
        begin
            k_reg    <= k_next;
            zero_reg <= zero_next;
        end
    end

    // The row of cells; the first cell mixes toward P_0 = 1.0.
    for (genvar j = 0; j < MAX_K; j++)
    begin : g_cell
        logic [PROB_W-1:0] below;
        if (j == 0)
        begin : g_first
            assign below = Q_ONE;
        end
        else
        begin : g_rest
            assign below = level[j-1];
        end
        krel_cell u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .p     (p_sat),
            .below (below),
            .level (level[j]),
            .held  (held[j])
        );
    end

    // Result selection and output register.
    krel_out #(
        .MAX_K (MAX_K),
        .IW    (IW)
    ) u_out (
        .clk                (clk),
        .rst_n              (rst_n),
        .take               (accept && last_component),
        .take_one           (k_one),
        .take_idx           (k_idx),
        .held               (held),
        .result_stall       (result_stall),
        .result_valid       (result_valid),
        .system_reliability (system_reliability),
        .hold_input         (hold_input)
    );

endmodule
